// ----- rtl/dsmc_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, types and control structs of the digit sum multiple counter
package dsmc_pkg;

  localparam int MAX_DIVISOR = 128;
  localparam int IDX_W       = $clog2(MAX_DIVISOR);
  localparam int DIV_W       = 8;
  localparam int CMP_W       = (DIV_W > IDX_W + 1) ? DIV_W : IDX_W + 1;
  localparam int CNT_W       = 30;
  localparam int DIG_W       = 4;
  localparam int RADIX       = 10;
  localparam int KCNT_W      = $clog2(RADIX + 1);

  localparam logic [CNT_W-1:0] MODP      = CNT_W'(1000000007);
  localparam logic [DIG_W-1:0] DIGIT_MAX = DIG_W'(RADIX - 1);
  localparam logic [DIV_W-1:0] DIV_RESET = DIV_W'(1);

  // apb register map, byte addresses
  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-1:0] REG_DIVISOR = ADDR_W'(0);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_RUN,
    ST_COMMIT
  } state_t;

  // sequencer to cell row
  typedef struct packed {
    logic             clr_acc;
    logic             shift;
    logic             add_en;
    logic             inc_en;
    logic             commit;
    logic             wipe;
    logic [IDX_W-1:0] dm1;
    logic [IDX_W-1:0] tight;
  } cell_ctl_t;

  // sequencer to output stage
  typedef struct packed {
    logic load_out;
    logic res_zero;
  } seq_stat_t;

endpackage

// ----- rtl/dsmc_cell.sv -----
`timescale 1ns / 1ps
// one residue cell: stationary table entry plus a travelling accumulator
module dsmc_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [dsmc_pkg::IDX_W-1:0]   cell_idx,
  input  dsmc_pkg::cell_ctl_t          ctl,
  input  logic [dsmc_pkg::CNT_W-1:0]   next_sum,
  input  logic [dsmc_pkg::CNT_W-1:0]   head_sum,
  output logic [dsmc_pkg::CNT_W-1:0]   sum_out,
  output logic [dsmc_pkg::CNT_W-1:0]   acc_out
);

  logic [dsmc_pkg::CNT_W-1:0] acc_r, acc_nxt;
  logic [dsmc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       active;
  logic                       is_tail;
  logic                       inc;
  logic [dsmc_pkg::CNT_W:0]   raw;
  logic [dsmc_pkg::CNT_W-1:0] red;

  assign active  = (cell_idx <= ctl.dm1);
  assign is_tail = (cell_idx == ctl.dm1);
  assign inc     = ctl.inc_en && (cell_idx == ctl.tight);

  // acc + entry + tight branch, one conditional subtract keeps it below the modulus
  assign raw = {1'b0, acc_r} + {1'b0, cnt_r} + {{dsmc_pkg::CNT_W{1'b0}}, inc};
  assign red = (raw >= {1'b0, dsmc_pkg::MODP}) ?
               dsmc_pkg::CNT_W'(raw - {1'b0, dsmc_pkg::MODP}) :
               raw[dsmc_pkg::CNT_W-1:0];

  assign sum_out = ctl.add_en ? red : acc_r;
  assign acc_out = acc_r;

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clr_acc) begin
      acc_nxt = '0;
    end else if (ctl.shift) begin
      acc_nxt = is_tail ? head_sum : next_sum;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.wipe) begin
      cnt_nxt = '0;
    end else if (ctl.commit) begin
      cnt_nxt = active ? acc_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/dsmc_seq.sv -----
`timescale 1ns / 1ps
// sequencer: digit intake, residue reduction, ring pass count and commit
module dsmc_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [dsmc_pkg::DIG_W-1:0]   in_digit,
  input  logic                         in_last,
  output logic                         in_ready,
  input  logic [dsmc_pkg::IDX_W-1:0]   dm1,
  input  logic                         out_busy,
  output dsmc_pkg::cell_ctl_t          ctl,
  output dsmc_pkg::seq_stat_t          stat
);

  dsmc_pkg::state_t state_r, state_nxt;

  logic [dsmc_pkg::DIG_W-1:0]  dig_r;
  logic                        last_r;
  logic [dsmc_pkg::IDX_W-1:0]  tight_r;
  logic [dsmc_pkg::IDX_W-1:0]  p_r;
  logic [dsmc_pkg::IDX_W-1:0]  pos_r;
  logic [dsmc_pkg::KCNT_W-1:0] k_r;
  logic                        stall;
  logic                        run_done;
  logic                        need_sub;

  assign stall    = last_r && out_busy;
  assign need_sub = (tight_r > dm1);
  assign run_done = (pos_r == dm1) && (k_r >= dsmc_pkg::KCNT_W'(dsmc_pkg::RADIX - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dsmc_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = dsmc_pkg::ST_REDUCE;
      end
      dsmc_pkg::ST_REDUCE: begin
        if (!need_sub) state_nxt = dsmc_pkg::ST_RUN;
      end
      dsmc_pkg::ST_RUN: begin
        if (run_done) state_nxt = dsmc_pkg::ST_COMMIT;
      end
      dsmc_pkg::ST_COMMIT: begin
        if (!stall) state_nxt = dsmc_pkg::ST_IDLE;
      end
      default: state_nxt = dsmc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    ctl.clr_acc    = 1'b0;
    ctl.shift      = 1'b0;
    ctl.add_en     = 1'b0;
    ctl.inc_en     = 1'b0;
    ctl.commit     = 1'b0;
    ctl.wipe       = 1'b0;
    ctl.dm1        = dm1;
    ctl.tight      = tight_r;
    stat.load_out  = 1'b0;
    stat.res_zero  = (p_r == '0);
    case (state_r)
      dsmc_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        ctl.clr_acc = 1'b1;
      end
      dsmc_pkg::ST_REDUCE: begin
      end
      dsmc_pkg::ST_RUN: begin
        ctl.shift  = 1'b1;
        ctl.add_en = (k_r < dsmc_pkg::KCNT_W'(dsmc_pkg::RADIX));
        ctl.inc_en = (k_r < dsmc_pkg::KCNT_W'(dig_r));
      end
      dsmc_pkg::ST_COMMIT: begin
        ctl.commit    = !stall;
        ctl.wipe      = !stall && last_r;
        stat.load_out = !stall && last_r;
      end
      default: begin
      end
    endcase
  end

  // payload of the digit in flight
  always_ff @(posedge clk) begin
    if (state_r == dsmc_pkg::ST_IDLE && in_valid) begin
      dig_r  <= (in_digit > dsmc_pkg::DIGIT_MAX) ? dsmc_pkg::DIGIT_MAX : in_digit;
      last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dsmc_pkg::ST_IDLE;
      tight_r <= '0;
      p_r     <= '0;
      pos_r   <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        dsmc_pkg::ST_REDUCE: begin
          if (need_sub) begin
            tight_r <= tight_r - dm1 - dsmc_pkg::IDX_W'(1);
          end else begin
            p_r   <= tight_r;
            pos_r <= '0;
            k_r   <= '0;
          end
        end
        dsmc_pkg::ST_RUN: begin
          pos_r <= (pos_r == dm1) ? '0 : pos_r + dsmc_pkg::IDX_W'(1);
          if (k_r < dsmc_pkg::KCNT_W'(dsmc_pkg::RADIX)) begin
            k_r <= k_r + dsmc_pkg::KCNT_W'(1);
          end
          if (k_r < dsmc_pkg::KCNT_W'(dig_r)) begin
            p_r <= (p_r == dm1) ? '0 : p_r + dsmc_pkg::IDX_W'(1);
          end
        end
        dsmc_pkg::ST_COMMIT: begin
          if (!stall) tight_r <= last_r ? '0 : p_r;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/digit_sum_multiple_counter.sv -----
`timescale 1ns / 1ps
// top level: apb divisor register, residue cell ring, sequencer and output register
//
// Counts n in 1..K whose decimal digit sum is a multiple of the divisor, mod 1e9+7.
// in_*  : one decimal digit of K per transfer, most significant first; in_tlast marks
//         the least significant digit. out_*: one count per bound, after its last digit.
// cfg_* : apb port, register 0 (byte address 0) is the 8-bit divisor; 0 acts as 1,
//         values above the cell count saturate. write it only while the block is idle.
// Per digit: intake, a check of the held residue plus repeated subtraction of the
// divisor when a divisor change leaves it too large, then the ring phase, which adds
// the ten digit values and ends only on a full turn of the ring, and a commit.
// During the ring phase accumulators travel one cell a cycle on the ring of residue
// cells and must make full turns.
// The count is registered and appears in the cycle after the last commit.
// A single output register holds the count; the next digit is still taken while it
// waits, and only the commit of a later final digit waits for out_tready.
// Reset (synchronous, active low) clears the table and residue, sets the divisor to 1.
module digit_sum_multiple_counter (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [3:0] digit, [7:4] zero
  input  logic        in_tlast,    // last_digit
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [29:0] count, [31:30] zero
  // apb configuration
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [dsmc_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);

  logic [dsmc_pkg::DIV_W-1:0] divisor_r;
  logic [dsmc_pkg::CMP_W-1:0] div_ext;
  logic [dsmc_pkg::CMP_W-1:0] d_eff;
  logic [dsmc_pkg::IDX_W-1:0] dm1;
  logic                       cfg_wr;

  dsmc_pkg::cell_ctl_t ctl;
  dsmc_pkg::seq_stat_t stat;

  logic [dsmc_pkg::CNT_W-1:0] sum_w [dsmc_pkg::MAX_DIVISOR];
  logic [dsmc_pkg::CNT_W-1:0] nxt_w [dsmc_pkg::MAX_DIVISOR];
  logic [dsmc_pkg::CNT_W-1:0] acc_w [dsmc_pkg::MAX_DIVISOR];

  logic                       out_valid_r;
  logic [dsmc_pkg::CNT_W-1:0] out_count_r;
  logic [dsmc_pkg::CNT_W-1:0] count_nxt;
  logic [dsmc_pkg::CNT_W-1:0] head_acc;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr == dsmc_pkg::REG_DIVISOR);
  assign cfg_prdata = (cfg_paddr == dsmc_pkg::REG_DIVISOR) ?
                      {{(32 - dsmc_pkg::DIV_W){1'b0}}, divisor_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divisor_r <= dsmc_pkg::DIV_RESET;
    end else if (cfg_wr) begin
      divisor_r <= cfg_pwdata[dsmc_pkg::DIV_W-1:0];
    end
  end

  // effective divisor: zero acts as one, large values saturate at the cell count
  assign div_ext = dsmc_pkg::CMP_W'(divisor_r);
  always_comb begin
    if (div_ext == '0) begin
      d_eff = dsmc_pkg::CMP_W'(1);
    end else if (div_ext > dsmc_pkg::CMP_W'(dsmc_pkg::MAX_DIVISOR)) begin
      d_eff = dsmc_pkg::CMP_W'(dsmc_pkg::MAX_DIVISOR);
    end else begin
      d_eff = div_ext;
    end
  end
  assign dm1 = dsmc_pkg::IDX_W'(d_eff - dsmc_pkg::CMP_W'(1));

  dsmc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_digit (in_tdata[dsmc_pkg::DIG_W-1:0]),
    .in_last  (in_tlast),
    .in_ready (in_tready),
    .dm1      (dm1),
    .out_busy (out_valid_r && !out_tready),
    .ctl      (ctl),
    .stat     (stat)
  );

  // ring of residue cells: in the run state accumulators move one cell down per cycle,
  // the tail cell (divisor - 1) picks up what leaves cell 0
  for (genvar i = 0; i < dsmc_pkg::MAX_DIVISOR; i++) begin : g_cell
    if (i == dsmc_pkg::MAX_DIVISOR - 1) begin : g_end
      assign nxt_w[i] = '0;
    end else begin : g_mid
      assign nxt_w[i] = sum_w[i+1];
    end

    dsmc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (dsmc_pkg::IDX_W'(i)),
      .ctl      (ctl),
      .next_sum (nxt_w[i]),
      .head_sum (sum_w[0]),
      .sum_out  (sum_w[i]),
      .acc_out  (acc_w[i])
    );
  end

  // count = entry 0 + (residue of K is zero) - 1, all mod 1e9+7
  assign head_acc = acc_w[0];
  always_comb begin
    if (stat.res_zero) begin
      count_nxt = head_acc;
    end else if (head_acc == '0) begin
      count_nxt = dsmc_pkg::MODP - dsmc_pkg::CNT_W'(1);
    end else begin
      count_nxt = head_acc - dsmc_pkg::CNT_W'(1);
    end
  end

  // output register, holds the count until its transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.load_out) begin
      out_count_r <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(32 - dsmc_pkg::CNT_W){1'b0}}, out_count_r};

endmodule
